### rtl/fdmg_pkg.sv
// Shared types and constants for the fast divisor magic generator.
// Used by every module of the block; depends on nothing.
package fdmg_pkg;

  localparam int unsigned DivW   = 64;
  localparam int unsigned ShiftW = 6;

  typedef struct packed {
    logic [DivW-1:0]   div;
    logic [DivW-1:0]   rem;
    logic [DivW-1:0]   quo;
    logic [ShiftW-1:0] lg;
    logic              zero;
    logic              pow2;
  } stage_t;

  typedef struct packed {
    logic [DivW-1:0]   magic;
    logic [ShiftW-1:0] shift;
    logic              zero;
  } result_t;

endpackage

### rtl/fast_divisor_magic_gen_core.sv
// Fast divisor magic generator: per 64-bit divisor, the branch-free multiplier and shift.
// Depends on fdmg_pkg, fdmg_prep, fdmg_div_step and fdmg_finish.
// Takes one divisor per cycle while no result waits in the skid entry; each result passes
// the front stage, the 64 single-bit restoring division stages, a rounding stage and the
// output register. A two-entry output buffer lets the pipeline hand over one more result after
// out_ready_i drops; in_ready_o depends only on registered state.
module fast_divisor_magic_gen_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] divisor_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] magic_o,
  output logic [5:0]  shift_o,
  output logic        divisor_zero_o
);
  import fdmg_pkg::*;

  logic    en;
  logic    pipe_valid [0:DivW];
  stage_t  pipe_stage [0:DivW];
  logic    fin_valid;
  result_t fin_res;

  logic    out_valid_q;
  result_t out_res_q;
  logic    skid_valid_q;
  result_t skid_res_q;
  logic    take;

  assign en         = ~skid_valid_q;
  assign in_ready_o = en;
  assign take       = out_valid_q & out_ready_i;

  fdmg_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .divisor_i (divisor_i),
    .valid_o   (pipe_valid[0]),
    .stage_o   (pipe_stage[0])
  );

  for (genvar k = 0; k < DivW; k++) begin : g_step
    fdmg_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (pipe_valid[k]),
      .stage_i (pipe_stage[k]),
      .valid_o (pipe_valid[k+1]),
      .stage_o (pipe_stage[k+1])
    );
  end

  fdmg_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pipe_valid[DivW]),
    .stage_i (pipe_stage[DivW]),
    .valid_o (fin_valid),
    .res_o   (fin_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || take) begin
      out_valid_q <= fin_valid;
    end else if (fin_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_res_q <= skid_res_q;
      end
    end else if (!out_valid_q || take) begin
      out_res_q <= fin_res;
    end else if (fin_valid) begin
      skid_res_q <= fin_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign magic_o        = out_res_q.magic;
  assign shift_o        = out_res_q.shift;
  assign divisor_zero_o = out_res_q.zero;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("buffered transaction without a held output");

  a_skid_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_res_q))
    else $error("buffered transaction lost while output stalled");

  a_zero_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divisor_zero_o |-> magic_o == '0 && shift_o == '0)
    else $error("zero divisor produced nonzero magic or shift");

endmodule

### rtl/fdmg_prep.sv
// Front stage: top set bit index, power-of-two and zero detection, divider seed.
// Depends on fdmg_pkg.
module fdmg_prep (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [63:0]             divisor_i,
  output logic                    valid_o,
  output fdmg_pkg::stage_t        stage_o
);
  import fdmg_pkg::*;

  logic             valid_q;
  stage_t           stage_d, stage_q;
  logic [ShiftW-1:0] lg;
  logic [DivW-1:0]  dm1;

  always_comb begin
    lg = '0;
    for (int i = 0; i < DivW; i++) begin
      if (divisor_i[i]) begin
        lg = i[ShiftW-1:0];
      end
    end
  end

  assign dm1 = divisor_i - {{(DivW-1){1'b0}}, 1'b1};

  always_comb begin
    stage_d.div  = divisor_i;
    stage_d.rem  = {{(DivW-1){1'b0}}, 1'b1} << lg;
    stage_d.quo  = '0;
    stage_d.lg   = lg;
    stage_d.zero = (divisor_i == '0);
    stage_d.pow2 = ((divisor_i & dm1) == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/fdmg_div_step.sv
// One registered step of the restoring 128/64 division: one quotient bit.
// Depends on fdmg_pkg.
module fdmg_div_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fdmg_pkg::stage_t stage_i,
  output logic             valid_o,
  output fdmg_pkg::stage_t stage_o
);
  import fdmg_pkg::*;

  logic          valid_q;
  stage_t        stage_d, stage_q;
  logic [DivW:0] sh;
  logic [DivW:0] dx;
  logic [DivW:0] diff;
  logic          ge;

  assign sh   = {stage_i.rem, 1'b0};
  assign dx   = {1'b0, stage_i.div};
  assign diff = sh - dx;
  assign ge   = (sh >= dx);

  always_comb begin
    stage_d     = stage_i;
    stage_d.rem = ge ? diff[DivW-1:0] : sh[DivW-1:0];
    stage_d.quo = {stage_i.quo[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

### rtl/fdmg_finish.sv
// Last stage: round the doubled quotient with the remainder, form magic and shift.
// Depends on fdmg_pkg.
module fdmg_finish (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fdmg_pkg::stage_t  stage_i,
  output logic              valid_o,
  output fdmg_pkg::result_t res_o
);
  import fdmg_pkg::*;

  logic          valid_q;
  result_t       res_d, res_q;
  logic [DivW:0] twice;
  logic          up;
  logic [DivW-1:0] inc;
  logic [DivW-1:0] mag;

  assign twice = {stage_i.rem, 1'b0};
  assign up    = (twice >= {1'b0, stage_i.div});
  assign inc   = up ? {{(DivW-2){1'b0}}, 2'b10} : {{(DivW-1){1'b0}}, 1'b1};
  assign mag   = {stage_i.quo[DivW-2:0], 1'b0} + inc;

  always_comb begin
    res_d.zero = stage_i.zero;
    if (stage_i.zero) begin
      res_d.magic = '0;
      res_d.shift = '0;
    end else if (stage_i.pow2) begin
      res_d.magic = '0;
      res_d.shift = stage_i.lg - {{(ShiftW-1){1'b0}}, 1'b1};
    end else begin
      res_d.magic = mag;
      res_d.shift = stage_i.lg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### tb/fast_divisor_magic_gen_core_test.sv
// Testbench for fast_divisor_magic_gen_core: drives 64-bit divisors, predicts multiplier,
// shift and zero flag per divisor, and compares every result in order.
// Depends on fdmg_pkg and the fast_divisor_magic_gen_core RTL.
module fast_divisor_magic_gen_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fdmg_pkg::*;

  typedef struct {
    logic [63:0] divisor;
    result_t     want;
  } magic_entry_t;

  class magic_scoreboard;
    magic_entry_t pending_magic[$];
    int unsigned  mismatches;
    int unsigned  compared;

    function new();
      mismatches = 0;
      compared   = 0;
    endfunction

    function result_t predict_magic(logic [63:0] d);
      result_t     r;
      int unsigned lg;
      logic [127:0] num;
      logic [127:0] quo;
      logic [127:0] rem;
      logic [64:0]  twice;
      logic [63:0]  m;
      r = '0;
      if (d == 64'd0) begin
        r.zero = 1'b1;
      end else begin
        lg = 0;
        for (int i = 0; i < 64; i++) begin
          if (d[i]) begin
            lg = i;
          end
        end
        if ((d & (d - 64'd1)) == 64'd0) begin
          r.magic = 64'd0;
          r.shift = ShiftW'(lg - 1);
        end else begin
          num   = 128'd1 << (64 + lg);
          quo   = num / {64'd0, d};
          rem   = num % {64'd0, d};
          m     = quo[63:0] << 1;
          twice = {rem[63:0], 1'b0};
          if (twice >= {1'b0, d}) begin
            m = m + 64'd1;
          end
          r.magic = m + 64'd1;
          r.shift = ShiftW'(lg);
        end
      end
      return r;
    endfunction

    function void note_divisor(logic [63:0] d);
      magic_entry_t e;
      e.divisor = d;
      e.want    = predict_magic(d);
      pending_magic.push_back(e);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(logic [63:0] magic, logic [5:0] shift, logic zero);
      magic_entry_t e;
      if (pending_magic.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: magic=%h shift=%0d zero=%0b",
                                  magic, shift, zero));
        return;
      end
      e = pending_magic.pop_front();
      compared++;
      if (magic !== e.want.magic) begin
        report_mismatch($sformatf("divisor %h: magic %h, want %h", e.divisor, magic,
                                  e.want.magic));
      end
      if (shift !== e.want.shift) begin
        report_mismatch($sformatf("divisor %h: shift %0d, want %0d", e.divisor, shift,
                                  e.want.shift));
      end
      if (zero !== e.want.zero) begin
        report_mismatch($sformatf("divisor %h: divisor_zero %0b, want %0b", e.divisor, zero,
                                  e.want.zero));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] divisor_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] magic_o;
  logic [5:0]  shift_o;
  logic        divisor_zero_o;

  magic_scoreboard sb;
  bit              calm = 1'b0;
  int unsigned     sent_total = 0;
  int unsigned     sent_zero  = 0;
  int unsigned     sent_pow2  = 0;

  fast_divisor_magic_gen_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .divisor_i     (divisor_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .magic_o       (magic_o),
    .shift_o       (shift_o),
    .divisor_zero_o(divisor_zero_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= calm || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(magic_o, shift_o, divisor_zero_o);
    end
  end

  task send_divisor(logic [63:0] d);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    divisor_i  <= d;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    sb.note_divisor(d);
    sent_total++;
    if (d == 64'd0) begin
      sent_zero++;
    end else if ((d & (d - 64'd1)) == 64'd0) begin
      sent_pow2++;
    end
  endtask

  function logic [63:0] random_divisor();
    logic [63:0] v;
    int unsigned sel;
    int unsigned k;
    sel = $urandom_range(99);
    k   = $urandom_range(63);
    v   = {$urandom, $urandom};
    if (sel < 35) begin
      return v;
    end else if (sel < 65) begin
      return v >> k;
    end else if (sel < 75) begin
      return 64'd1 << k;
    end else if (sel < 85) begin
      if ($urandom_range(1)) begin
        return (64'd1 << k) + 64'($urandom_range(3));
      end
      return (64'd1 << k) - 64'($urandom_range(3));
    end else if (sel < 92) begin
      return 64'($urandom_range(300, 1));
    end else if (sel < 95) begin
      return 64'd0;
    end
    return ~64'($urandom_range(255));
  endfunction

  initial begin
    logic [63:0] directed[$];
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    divisor_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero, one, powers of two at both ends, neighbors of powers, and odd patterns
    directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd5, 64'd6, 64'd7, 64'd10,
                 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h4000_0000_0000_0000,
                 64'h0000_0001_0000_0000, 64'h0000_0000_FFFF_FFFF,
                 64'h0000_0001_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'hC000_0000_0000_0000,
                 64'd641, 64'd1000000007, 64'd0};
    foreach (directed[i]) begin
      send_divisor(directed[i]);
    end

    for (int n = 0; n < 750; n++) begin
      calm = (n >= 300 && n < 450);
      send_divisor(random_divisor());
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending_magic.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);

    $display("Sent %0d divisors (%0d zero, %0d powers of two); %0d results compared.",
             sent_total, sent_zero, sent_pow2, sb.compared);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d results still pending.", sb.pending_magic.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
